// ===== hw/rtl/jsfe_pkg.sv =====
// Package for the JSON string field extractor.
// Beat types, phase and kind codes, character constants. No dependencies.
package jsfe_pkg;

    localparam int KEY_MAX_DEF = 8;
    localparam int KEY_BYTES   = 8;
    localparam int KEY_CHARS_W = 8 * KEY_BYTES;
    localparam int KEY_LEN_W   = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = 1;
    localparam int Q_CNT_W     = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_CHARS  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH = 1'd1;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [1:0] {
        KIND_CHAR         = 2'd0,
        KIND_COMPLETE     = 2'd1,
        KIND_UNTERMINATED = 2'd2,
        KIND_NOVALUE      = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_COLON,
        PH_SPACE,
        PH_STRING,
        PH_ESCAPE,
        PH_DONE,
        PH_NOVALUE
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       doc_end;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       out_last;
    } out_beat_t;

    // Shift/clear control shared by every window cell.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    // What one cell checks: a key character or the opening quote at the far end.
    typedef struct packed {
        logic is_key;
        logic is_tail;
    } cell_role_t;

    // Results caused by one input byte.
    typedef struct packed {
        logic       has_char;
        logic [7:0] char_byte;
        logic       has_status;
        kind_t      status;
    } q_entry_t;

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        begin
            case (c)
                CH_B:    r = CH_BS;
                CH_F:    r = CH_FF;
                CH_N:    r = CH_LF;
                CH_R:    r = CH_CR;
                CH_T:    r = CH_TAB;
                default: r = c;
            endcase
            return r;
        end
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

// ===== hw/rtl/jsfe_cell.sv =====
// One window cell: holds a byte and its fill bit, passes both to the next cell.
// Depends on jsfe_pkg.
module jsfe_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  jsfe_pkg::cell_ctl_t   ctl,
    input  jsfe_pkg::cell_role_t  role,
    input  logic [7:0]            byte_in,
    input  logic                  valid_in,
    input  logic [7:0]            key_byte,
    output logic [7:0]            byte_out,
    output logic                  valid_out,
    output logic                  ok
);

    logic [7:0] byte_reg;
    logic       valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            byte_reg <= byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_reg <= valid_in;
        end
    end

    always_comb
    begin
        if (role.is_key)
        begin
            ok = (byte_reg == key_byte);
        end
        else if (role.is_tail)
        begin
            ok = valid_reg && (byte_reg == jsfe_pkg::CH_QUOTE);
        end
        else
        begin
            ok = 1'b1;
        end
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

// ===== hw/rtl/jsfe_window.sv =====
// Row of window cells and the quoted-key match over it.
// Depends on jsfe_pkg and jsfe_cell.
module jsfe_window #(
    parameter int KEY_MAX = jsfe_pkg::KEY_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  jsfe_pkg::cell_ctl_t                 ctl,
    input  logic [7:0]                          in_byte,
    input  logic [jsfe_pkg::KEY_CHARS_W-1:0]    key_chars,
    input  logic [jsfe_pkg::KEY_LEN_W-1:0]      key_len,
    output logic                                match
);

    localparam int CELLS = KEY_MAX + 1;

    logic [7:0]       cell_byte [CELLS];
    logic [CELLS-1:0] cell_valid;
    logic [CELLS-1:0] cell_ok;

    // Cell k sits at window position k+1 once the new byte lands at position 0.
    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        localparam logic [jsfe_pkg::KEY_LEN_W-1:0] POS = jsfe_pkg::KEY_LEN_W'(k);
        jsfe_pkg::cell_role_t               role;
        logic [jsfe_pkg::KEY_LEN_W-1:0]     key_idx;
        logic [7:0]                         key_byte;
        logic [7:0]                         byte_in;
        logic                               valid_in;

        always_comb
        begin
            role.is_key  = POS < key_len;
            role.is_tail = POS == key_len;
            key_idx      = key_len - POS - jsfe_pkg::KEY_LEN_W'(1);
            key_byte     = key_chars[8 * key_idx[2:0] +: 8];
        end

        if (k == 0)
        begin : g_head
            assign byte_in  = in_byte;
            assign valid_in = 1'b1;
        end
        else
        begin : g_link
            assign byte_in  = cell_byte[k-1];
            assign valid_in = cell_valid[k-1];
        end

        jsfe_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .role      (role),
            .byte_in   (byte_in),
            .valid_in  (valid_in),
            .key_byte  (key_byte),
            .byte_out  (cell_byte[k]),
            .valid_out (cell_valid[k]),
            .ok        (cell_ok[k])
        );
    end

    assign match = (in_byte == jsfe_pkg::CH_QUOTE) && (&cell_ok);

endmodule

// ===== hw/rtl/jsfe_out_queue.sv =====
// Result queue: one entry per input byte that causes results, char then status.
// Depends on jsfe_pkg.
module jsfe_out_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  jsfe_pkg::q_entry_t    push_entry,
    output logic                  full,
    output logic                  out_valid,
    input  logic                  out_stall,
    output jsfe_pkg::out_beat_t   out_data
);

    jsfe_pkg::q_entry_t                  entry_reg [jsfe_pkg::Q_DEPTH];
    logic [jsfe_pkg::Q_PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [jsfe_pkg::Q_PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [jsfe_pkg::Q_CNT_W-1:0]        count_reg, count_next;
    logic                                char_sent_reg, char_sent_next;
    jsfe_pkg::q_entry_t                  head;
    logic                                show_char;
    logic                                beat;
    logic                                retire;

    function automatic logic [jsfe_pkg::Q_CNT_W-1:0] Q_CNT_ONE(input logic b);
        return {{(jsfe_pkg::Q_CNT_W-1){1'b0}}, b};
    endfunction

    assign head      = entry_reg[rd_ptr_reg];
    assign out_valid = count_reg != '0;
    assign full      = count_reg == jsfe_pkg::Q_CNT_W'(jsfe_pkg::Q_DEPTH);
    assign show_char = head.has_char && !char_sent_reg;

    always_comb
    begin
        if (show_char)
        begin
            out_data.out_byte = head.char_byte;
            out_data.out_kind = jsfe_pkg::KIND_CHAR;
            out_data.out_last = !head.has_status;
        end
        else
        begin
            out_data.out_byte = 8'd0;
            out_data.out_kind = head.status;
            out_data.out_last = 1'b1;
        end
    end

    assign beat   = out_valid && !out_stall;
    assign retire = beat && out_data.out_last;

    always_comb
    begin
        wr_ptr_next    = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next    = retire ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next     = count_reg + Q_CNT_ONE(push) - Q_CNT_ONE(retire);
        char_sent_next = retire ? 1'b0 : (beat ? 1'b1 : char_sent_reg);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            char_sent_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            char_sent_reg <= char_sent_next;
        end
    end

endmodule

// ===== hw/rtl/json_string_field_extractor.sv =====
// JSON string field extractor, top level.
// Depends on jsfe_pkg, jsfe_window, jsfe_out_queue.
//
// Feed a document one byte per beat, doc_end high on its last byte. The block
// looks for the first occurrence of the configured key in double quotes
// (key_chars, first character in the low byte; key_length 0..KEY_MAX, larger
// values act as KEY_MAX, zero matches two adjacent quotes). After the match it
// waits for a colon, skips whitespace and needs an opening quote; then each
// string byte comes out as a character beat, with backslash escapes decoded
// (b f n r t mapped, anything else passed through as the escaped byte). The
// last byte of a document always yields one status beat: complete,
// unterminated, or no value; a byte may give a character and then a status.
// out_last marks the final result beat of one input byte. After the status
// the search state restarts; the configuration is kept. Rate: one byte per
// cycle sustained, in_stall is set only by a full two-entry result queue, so
// a byte that yields two beats keeps its queue entry until both are taken. The
// byte that completes the quoted key is compared against a row of KEY_MAX+1
// window cells in the same cycle it is taken. Write configuration only while
// the block is idle; cfg_ready is always high.
module json_string_field_extractor #(
    parameter int KEY_MAX = jsfe_pkg::KEY_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  jsfe_pkg::in_beat_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output jsfe_pkg::out_beat_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jsfe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [jsfe_pkg::KEY_CHARS_W-1:0]    cfg_data
);

    logic [jsfe_pkg::KEY_CHARS_W-1:0]  key_chars_reg;
    logic [jsfe_pkg::KEY_LEN_W-1:0]    key_length_reg;
    logic [jsfe_pkg::KEY_LEN_W-1:0]    key_len;
    jsfe_pkg::phase_t                  phase_reg, phase_next, phase_step;
    jsfe_pkg::cell_ctl_t               win_ctl;
    jsfe_pkg::q_entry_t                q_entry;
    logic                              accept;
    logic                              match;
    logic                              q_full;
    logic [7:0]                        c;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_chars_reg  <= '0;
            key_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                jsfe_pkg::CFG_KEY_CHARS:  key_chars_reg  <= cfg_data;
                jsfe_pkg::CFG_KEY_LENGTH: key_length_reg <= cfg_data[jsfe_pkg::KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign key_len = (key_length_reg > jsfe_pkg::KEY_LEN_W'(KEY_MAX))
                   ? jsfe_pkg::KEY_LEN_W'(KEY_MAX) : key_length_reg;

    // ---------------- input side ----------------
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign c        = in_data.in_byte;

    // Window shifts on every accepted byte, empties at document end.
    assign win_ctl.shift = accept;
    assign win_ctl.clear = accept && in_data.doc_end;

    jsfe_window #(
        .KEY_MAX (KEY_MAX)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (win_ctl),
        .in_byte   (c),
        .key_chars (key_chars_reg),
        .key_len   (key_len),
        .match     (match)
    );

    // ---------------- phase machine: next state ----------------
    always_comb
    begin
        case (phase_reg)
            jsfe_pkg::PH_SEARCH:
                phase_step = match ? jsfe_pkg::PH_COLON : jsfe_pkg::PH_SEARCH;
            jsfe_pkg::PH_COLON:
                phase_step = (c == jsfe_pkg::CH_COLON) ? jsfe_pkg::PH_SPACE
                                                       : jsfe_pkg::PH_COLON;
            jsfe_pkg::PH_SPACE:
            begin
                if (c == jsfe_pkg::CH_QUOTE)
                begin
                    phase_step = jsfe_pkg::PH_STRING;
                end
                else if (!jsfe_pkg::is_ws(c))
                begin
                    phase_step = jsfe_pkg::PH_NOVALUE;
                end
                else
                begin
                    phase_step = jsfe_pkg::PH_SPACE;
                end
            end
            jsfe_pkg::PH_STRING:
            begin
                if (c == jsfe_pkg::CH_BSLASH)
                begin
                    phase_step = jsfe_pkg::PH_ESCAPE;
                end
                else if (c == jsfe_pkg::CH_QUOTE)
                begin
                    phase_step = jsfe_pkg::PH_DONE;
                end
                else
                begin
                    phase_step = jsfe_pkg::PH_STRING;
                end
            end
            jsfe_pkg::PH_ESCAPE:
                phase_step = jsfe_pkg::PH_STRING;
            default:
                phase_step = phase_reg;
        endcase

        if (!accept)
        begin
            phase_next = phase_reg;
        end
        else if (in_data.doc_end)
        begin
            phase_next = jsfe_pkg::PH_SEARCH;
        end
        else
        begin
            phase_next = phase_step;
        end
    end

    // ---------------- phase machine: outputs ----------------
    always_comb
    begin
        q_entry.has_char   = 1'b0;
        q_entry.char_byte  = c;
        q_entry.has_status = accept && in_data.doc_end;
        case (phase_reg)
            jsfe_pkg::PH_STRING:
                q_entry.has_char = accept && (c != jsfe_pkg::CH_BSLASH)
                                   && (c != jsfe_pkg::CH_QUOTE);
            jsfe_pkg::PH_ESCAPE:
            begin
                q_entry.has_char  = accept;
                q_entry.char_byte = jsfe_pkg::unescape(c);
            end
            default: ;
        endcase
        case (phase_step)
            jsfe_pkg::PH_DONE:   q_entry.status = jsfe_pkg::KIND_COMPLETE;
            jsfe_pkg::PH_STRING,
            jsfe_pkg::PH_ESCAPE: q_entry.status = jsfe_pkg::KIND_UNTERMINATED;
            default:             q_entry.status = jsfe_pkg::KIND_NOVALUE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= jsfe_pkg::PH_SEARCH;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // ---------------- result queue ----------------
    jsfe_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_entry.has_char || q_entry.has_status),
        .push_entry (q_entry),
        .full       (q_full),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    // ---------------- assertions ----------------
    // Status beats always close the group for their input byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.out_kind != jsfe_pkg::KIND_CHAR) |-> out_data.out_last)
        else $error("status beat without out_last");

    // A non-final beat can only be a character followed by its status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.out_last |-> out_data.out_kind == jsfe_pkg::KIND_CHAR)
        else $error("non-final beat is not a character");

    // Status beats carry a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.out_kind != jsfe_pkg::KIND_CHAR) |-> out_data.out_byte == 8'd0)
        else $error("status beat with nonzero byte");

    // Document end restarts the search.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.doc_end |=> phase_reg == jsfe_pkg::PH_SEARCH)
        else $error("phase not reset after document end");

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for json_string_field_extractor: directed and random documents.
// Uses jsfe_pkg for the beat types, kinds, register indexes and character codes.
// Carries its own copy of the key search and string decoding to work out the output beats.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_MAX       = jsfe_pkg::KEY_MAX_DEF;
    localparam int WIN_DEPTH     = KEY_MAX + 2;  // quote, key, quote
    localparam int SETTLE_CYCLES = 8;            // a byte with no result may still be in flight
    localparam int KEY_SWAP_BYTES = 150;         // re-key this often during random traffic
    localparam logic [7:0] CH_VT = 8'h0B;        // vertical tab, the one blank not in the package

    // ------------------------------------------------------------------
    // DUT hookup. Every input has a known value from time zero.
    // ------------------------------------------------------------------
    logic                             clk;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_stall;
    jsfe_pkg::in_beat_t               in_data   = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    jsfe_pkg::out_beat_t              out_data;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [jsfe_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [jsfe_pkg::KEY_CHARS_W-1:0] cfg_data  = '0;

    json_string_field_extractor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: key registers plus per-document scan state.
    // ------------------------------------------------------------------
    logic [jsfe_pkg::KEY_CHARS_W-1:0] key_bytes = '0;
    logic [jsfe_pkg::KEY_LEN_W-1:0]   key_len   = '0;
    logic [7:0]                       win_bytes [WIN_DEPTH];  // newest byte at index 0
    int                               win_fill;               // saturates at WIN_DEPTH
    jsfe_pkg::phase_t                 scan_phase;

    jsfe_pkg::out_beat_t decoded_due [$];   // beats the block still owes, oldest first
    int                  bad_beats = 0;

    // Knobs shared by the driver, the output side and the tests.
    int src_idle_pct    = 0;
    int rcv_idle_pct    = 0;
    int hold_cycles_req = 0;

    function automatic void clear_scan();
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            win_bytes[i] = 8'h00;
        end
        win_fill   = 0;
        scan_phase = jsfe_pkg::PH_SEARCH;
    endfunction

    function automatic int eff_key_len();
        return (key_len > KEY_MAX) ? KEY_MAX : int'(key_len);
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == jsfe_pkg::CH_SPACE || c == jsfe_pkg::CH_TAB || c == jsfe_pkg::CH_LF ||
               c == CH_VT || c == jsfe_pkg::CH_FF || c == jsfe_pkg::CH_CR;
    endfunction

    function automatic logic [7:0] decode_escape(input logic [7:0] c);
        case (c)
            jsfe_pkg::CH_B: return jsfe_pkg::CH_BS;
            jsfe_pkg::CH_F: return jsfe_pkg::CH_FF;
            jsfe_pkg::CH_N: return jsfe_pkg::CH_LF;
            jsfe_pkg::CH_R: return jsfe_pkg::CH_CR;
            jsfe_pkg::CH_T: return jsfe_pkg::CH_TAB;
            default:        return c;   // quote, backslash, slash and anything unknown pass through
        endcase
    endfunction

    // Quoted key sitting in the window? Opening quote is the oldest byte of the span.
    function automatic bit key_in_window();
        int len;
        int span;
        len  = eff_key_len();
        span = len + 2;
        if (win_fill < span)
            return 1'b0;
        if (win_bytes[0] != jsfe_pkg::CH_QUOTE || win_bytes[span-1] != jsfe_pkg::CH_QUOTE)
            return 1'b0;
        for (int i = 0; i < len; i++)
        begin
            if (win_bytes[span-2-i] != key_bytes[8*i +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // One accepted byte: advance the scan and queue the beats it owes (0..2).
    function automatic void extract_step(input logic [7:0] c, input logic doc_last);
        jsfe_pkg::out_beat_t beats [$];
        jsfe_pkg::out_beat_t b;
        for (int i = WIN_DEPTH - 1; i > 0; i--)
        begin
            win_bytes[i] = win_bytes[i-1];
        end
        win_bytes[0] = c;
        if (win_fill < WIN_DEPTH)
            win_fill++;

        b.out_last = 1'b0;
        case (scan_phase)
            jsfe_pkg::PH_SEARCH:
            begin
                if (key_in_window())
                    scan_phase = jsfe_pkg::PH_COLON;
            end
            jsfe_pkg::PH_COLON:
            begin
                if (c == jsfe_pkg::CH_COLON)
                    scan_phase = jsfe_pkg::PH_SPACE;
            end
            jsfe_pkg::PH_SPACE:
            begin
                if (c == jsfe_pkg::CH_QUOTE)
                    scan_phase = jsfe_pkg::PH_STRING;
                else if (!is_blank(c))
                    scan_phase = jsfe_pkg::PH_NOVALUE;
            end
            jsfe_pkg::PH_STRING:
            begin
                if (c == jsfe_pkg::CH_BSLASH)
                    scan_phase = jsfe_pkg::PH_ESCAPE;
                else if (c == jsfe_pkg::CH_QUOTE)
                    scan_phase = jsfe_pkg::PH_DONE;
                else
                begin
                    b.out_byte = c;
                    b.out_kind = jsfe_pkg::KIND_CHAR;
                    beats = {beats, b};
                end
            end
            jsfe_pkg::PH_ESCAPE:
            begin
                b.out_byte = decode_escape(c);
                b.out_kind = jsfe_pkg::KIND_CHAR;
                beats = {beats, b};
                scan_phase = jsfe_pkg::PH_STRING;
            end
            default:
            begin
            end
        endcase

        // Last byte of the document: exactly one status, then a fresh search.
        if (doc_last)
        begin
            b.out_byte = 8'h00;
            if (scan_phase == jsfe_pkg::PH_DONE)
                b.out_kind = jsfe_pkg::KIND_COMPLETE;
            else if (scan_phase == jsfe_pkg::PH_STRING || scan_phase == jsfe_pkg::PH_ESCAPE)
                b.out_kind = jsfe_pkg::KIND_UNTERMINATED;
            else
                b.out_kind = jsfe_pkg::KIND_NOVALUE;
            beats = {beats, b};
            clear_scan();
        end

        if (beats.size() > 0)
            beats[beats.size()-1].out_last = 1'b1;
        foreach (beats[i])
        begin
            decoded_due = {decoded_due, beats[i]};
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side. Valid stays high from one beat to the next unless an idle
    // gap is drawn; data only moves after the beat is taken.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] c, input logic doc_last);
        jsfe_pkg::in_beat_t b;
        b.in_byte = c;
        b.doc_end = doc_last;
        if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (in_stall);
        extract_step(c, doc_last);
    endtask

    task automatic send_text(input string s, input bit ends_doc);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], ends_doc && (i == s.len() - 1));
        end
    endtask

    // Drop valid, wait for every owed beat, then let the pipe go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (decoded_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; valid drops on the step after the write lands.
    task automatic write_reg(input logic [jsfe_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == jsfe_pkg::CFG_KEY_CHARS)
            key_bytes = value;
        else if (idx == jsfe_pkg::CFG_KEY_LENGTH)
            key_len = value[jsfe_pkg::KEY_LEN_W-1:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Registers change only with the block idle and between documents.
    task automatic load_key(input logic [63:0] chars, input logic [63:0] len_word);
        settle();
        write_reg(jsfe_pkg::CFG_KEY_CHARS, chars);
        write_reg(jsfe_pkg::CFG_KEY_LENGTH, len_word);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall, optional long hold-off, and the compare.
    // Sampled right at the edge, compared 1 ns later so expectations queued
    // at the same edge are already in place.
    // ------------------------------------------------------------------
    task automatic check_beat(input jsfe_pkg::out_beat_t got);
        jsfe_pkg::out_beat_t want;
        if (decoded_due.size() == 0)
        begin
            $error("unexpected beat: out_byte %02h out_kind %0d out_last %0b",
                   got.out_byte, got.out_kind, got.out_last);
            bad_beats++;
        end
        else
        begin
            want = decoded_due.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
                bad_beats++;
            end
            if (got.out_kind !== want.out_kind)
            begin
                $error("out_kind: expected %0d, actual %0d", want.out_kind, got.out_kind);
                bad_beats++;
            end
            if (got.out_last !== want.out_last)
            begin
                $error("out_last: expected %0b, actual %0b", want.out_last, got.out_last);
                bad_beats++;
            end
        end
    endtask

    initial
    begin : out_side
        int                  hold_left;
        bit                  took;
        jsfe_pkg::out_beat_t seen;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            took = (out_valid === 1'b1) && (out_stall === 1'b0);
            seen = out_data;
            if (hold_cycles_req > 0)
            begin
                hold_left       = hold_cycles_req;
                hold_cycles_req = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= (rcv_idle_pct > 0) && ($urandom_range(0, 99) < rcv_idle_pct);
            end
            if (took)
            begin
                #1;
                check_beat(seen);
            end
        end
    end

    // ------------------------------------------------------------------
    // Random document pieces.
    // ------------------------------------------------------------------
    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 5))
            0:       return jsfe_pkg::CH_SPACE;
            1:       return jsfe_pkg::CH_TAB;
            2:       return jsfe_pkg::CH_LF;
            3:       return CH_VT;
            4:       return jsfe_pkg::CH_FF;
            default: return jsfe_pkg::CH_CR;
        endcase
    endfunction

    // Filler around the field: heavy on quotes, colons and key bytes to tease
    // false matches, plus raw bytes so every bit toggles.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 9))
            0, 1:    return jsfe_pkg::CH_QUOTE;
            2:       return jsfe_pkg::CH_COLON;
            3:       return key_bytes[8*$urandom_range(0, jsfe_pkg::KEY_BYTES-1) +: 8];
            4, 5, 6: return 8'($urandom_range(0, 255));
            default: return 8'("a" + $urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        do
            c = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(8'h20, 8'h7E));
        while (c == jsfe_pkg::CH_QUOTE || c == jsfe_pkg::CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] escape_pick();
        case ($urandom_range(0, 9))
            0:       return jsfe_pkg::CH_B;
            1:       return jsfe_pkg::CH_F;
            2:       return jsfe_pkg::CH_N;
            3:       return jsfe_pkg::CH_R;
            4:       return jsfe_pkg::CH_T;
            5:       return jsfe_pkg::CH_QUOTE;
            6:       return jsfe_pkg::CH_BSLASH;
            7:       return jsfe_pkg::CH_SLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Key bytes: mostly letters, sometimes any byte but a colon.
    function automatic logic [7:0] key_char_pick();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0)
            return 8'("a" + $urandom_range(0, 25));
        do
            c = 8'($urandom_range(0, 255));
        while (c == jsfe_pkg::CH_COLON);
        return c;
    endfunction

    task automatic load_random_key();
        logic [63:0] chars;
        int          len;
        for (int i = 0; i < jsfe_pkg::KEY_BYTES; i++)
        begin
            chars[8*i +: 8] = key_char_pick();
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: len = $urandom_range(1, 4);
            6:                len = 0;
            7:                len = $urandom_range(5, 8);
            default:          len = $urandom_range(9, 15);   // clamps to KEY_MAX
        endcase
        load_key(chars, 64'(len));
    endtask

    // Mostly a well-formed "key": "value" with random content; each piece can
    // go missing or be damaged, and the document can be cut anywhere.
    task automatic send_random_doc(output int nbytes);
        logic [7:0] doc [$];
        int         eff;
        int         cut;
        eff = eff_key_len();
        repeat ($urandom_range(0, 4)) doc = {doc, noise_byte()};
        if ($urandom_range(0, 99) < 88)
        begin
            doc = {doc, jsfe_pkg::CH_QUOTE};
            for (int i = 0; i < eff; i++)
            begin
                doc = {doc, key_bytes[8*i +: 8]};
            end
            if (eff > 0 && $urandom_range(0, 99) < 10)
                doc[doc.size() - 1 - $urandom_range(0, eff - 1)] = noise_byte();
            doc = {doc, jsfe_pkg::CH_QUOTE};
        end
        repeat ($urandom_range(0, 2)) doc = {doc, blank_byte()};
        if ($urandom_range(0, 99) < 92)
            doc = {doc, jsfe_pkg::CH_COLON};
        repeat ($urandom_range(0, 3)) doc = {doc, blank_byte()};
        if ($urandom_range(0, 99) < 88)
            doc = {doc, jsfe_pkg::CH_QUOTE};
        else
            doc = {doc, noise_byte()};
        repeat ($urandom_range(0, 10))
        begin
            if ($urandom_range(0, 99) < 25)
            begin
                doc = {doc, jsfe_pkg::CH_BSLASH};
                doc = {doc, escape_pick()};
            end
            else
            begin
                doc = {doc, text_byte()};
            end
        end
        if ($urandom_range(0, 99) < 85)
            doc = {doc, jsfe_pkg::CH_QUOTE};
        repeat ($urandom_range(0, 3)) doc = {doc, noise_byte()};
        if ($urandom_range(0, 99) < 15)
        begin
            cut = $urandom_range(1, doc.size());
            while (doc.size() > cut)
            begin
                void'(doc.pop_back());
            end
        end
        foreach (doc[i])
        begin
            send_byte(doc[i], i == doc.size() - 1);
        end
        nbytes = doc.size();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every escape, an unknown escape, and a document that ends on a lone backslash.
    task automatic test_escapes();
        load_key(64'h6B, 64'd1);   // "k"
        send_text("\"k\": \"\\b\\f\\n\\r\\t\\/\\\"\\\\\\q", 1'b0);
        send_text("\\", 1'b1);
    endtask

    // Byte extremes inside a value, junk after the close, non-string value,
    // end before the value, one-byte document, char and status on one byte.
    task automatic test_value_shapes();
        send_text("\"k\":\t\"", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("\"x", 1'b1);
        send_text("\"k\":7\"", 1'b1);
        send_text("x\"k\"", 1'b1);
        send_byte(8'hFF, 1'b1);
        send_text("\"k\":\"ab", 1'b1);
    endtask

    // Empty key, oversize length (with junk above the length field),
    // and an all-ones key at the full width.
    task automatic test_key_edges();
        load_key(64'h0, 64'd0);
        send_text("\"\":\"z\"", 1'b1);
        load_key(64'h4847_4645_4443_4241, 64'hFFFF_FFFF_FFFF_FFFC);   // "ABCDEFGH", len 12
        send_text("\"ABCDEFGH\":\"", 1'b1);
        load_key('1, 64'd8);
        send_byte(jsfe_pkg::CH_QUOTE, 1'b0);
        repeat (jsfe_pkg::KEY_BYTES) send_byte(8'hFF, 1'b0);
        send_text("\":\"\"", 1'b1);
    endtask

    // Receiver holds off for a long stretch while a long value keeps coming,
    // so the result queue fills and the input side has to stall.
    task automatic test_output_holdoff();
        load_key(64'h6B, 64'd1);
        hold_cycles_req = 120;
        send_text("\"k\":\"0123456789abcdefghij\"", 1'b1);
        settle();
    endtask

    task automatic test_random_docs(input int src_pct, input int rcv_pct, input int nbytes);
        int sent;
        int since_key;
        int n;
        settle();
        src_idle_pct = src_pct;
        rcv_idle_pct = rcv_pct;
        sent      = 0;
        since_key = KEY_SWAP_BYTES;
        while (sent < nbytes)
        begin
            if (since_key >= KEY_SWAP_BYTES)
            begin
                load_random_key();
                since_key = 0;
            end
            send_random_doc(n);
            sent      += n;
            since_key += n;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        clear_scan();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 18;
        rcv_idle_pct = 88;
        test_escapes();
        test_value_shapes();
        test_key_edges();

        test_random_docs(18, 88, 530);
        test_random_docs(88, 18, 530);
        test_random_docs(0, 0, 280);
        test_output_holdoff();
        test_random_docs(0, 0, 270);

        settle();
        if (bad_beats == 0 && decoded_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Generous ceiling: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/jsfe_pkg.sv
hw/rtl/jsfe_cell.sv
hw/rtl/jsfe_window.sv
hw/rtl/jsfe_out_queue.sv
hw/rtl/json_string_field_extractor.sv
verif/tb.sv
